FILE: hdl/usv_pkg.sv
package usv_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        V_VALID    = 3'd0,
        V_ASCII    = 3'd1,
        V_BAD_LEAD = 3'd2,
        V_BAD_CONT = 3'd3,
        V_TRUNC    = 3'd4
    } verdict_t;

    // classified word handed from front to back
    typedef struct packed {
        logic       top_bit;
        logic       is_cont;
        logic       bad_lead;
        logic [2:0] pend_init;
        logic       last;
    } cls_t;

    typedef struct packed {
        logic       all_ascii;
        logic [2:0] pending;
        verdict_t   first_error;
    } back_status_t;

endpackage

FILE: hdl/usv_front.sv
module usv_front #(
    parameter int MAX_SEQ_LEN = 6
) (
    input  logic          [7:0] data_byte,
    input  logic                last_byte,
    output usv_pkg::cls_t       cls
);
    import usv_pkg::*;

    logic [3:0] lead_n;
    logic       run;

    always_comb
    begin
        lead_n = 4'd0;
        run    = 1'b1;
        for (int i = 7; i >= 0; i--)
        begin
            if (run && data_byte[i])
            begin
                lead_n = lead_n + 4'd1;
            end
            else
            begin
                run = 1'b0;
            end
        end
    end

    always_comb
    begin
        cls.top_bit   = data_byte[7];
        cls.is_cont   = (data_byte[7:6] == 2'b10);
        cls.bad_lead  = (lead_n < 4'd2) || (lead_n > 4'(MAX_SEQ_LEN));
        cls.pend_init = 3'(lead_n - 4'd1);
        cls.last      = last_byte;
    end

endmodule

FILE: hdl/usv_queue.sv
module usv_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  usv_pkg::cls_t wr_data,
    input  logic          rd_en,
    output usv_pkg::cls_t rd_data,
    output logic          q_full,
    output logic          q_empty
);
    import usv_pkg::*;

    cls_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    assign q_full  = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/usv_back.sv
module usv_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  usv_pkg::cls_t         cls,
    input  logic                  cls_avail,
    output logic                  cls_take,
    input  logic                  pop,
    output logic                  empty,
    output logic                  is_utf8,
    output logic            [2:0] verdict_code,
    output usv_pkg::back_status_t status
);
    import usv_pkg::*;

    logic       all_ascii_reg, all_ascii_next;
    logic [2:0] pending_reg, pending_next;
    verdict_t   err_reg, err_next;
    logic       out_valid_reg, out_valid_next;
    verdict_t   out_code_reg, out_code_next;
    verdict_t   verdict;

    assign cls_take = cls_avail && (!cls.last || !out_valid_reg || pop);

    always_comb
    begin
        all_ascii_next = all_ascii_reg & ~cls.top_bit;
        pending_next   = pending_reg;
        err_next       = err_reg;
        if (err_reg == V_VALID)
        begin
            if (pending_reg == 3'd0)
            begin
                if (cls.top_bit)
                begin
                    if (cls.bad_lead)
                    begin
                        err_next = V_BAD_LEAD;
                    end
                    else
                    begin
                        pending_next = cls.pend_init;
                    end
                end
            end
            else if (!cls.is_cont)
            begin
                err_next = V_BAD_CONT;
            end
            else
            begin
                pending_next = pending_reg - 3'd1;
            end
        end

        if (err_next != V_VALID)
        begin
            verdict = err_next;
        end
        else if (all_ascii_next)
        begin
            verdict = V_ASCII;
        end
        else if (pending_next != 3'd0)
        begin
            verdict = V_TRUNC;
        end
        else
        begin
            verdict = V_VALID;
        end

        out_valid_next = out_valid_reg && !pop;
        out_code_next  = out_code_reg;
        if (cls_take && cls.last)
        begin
            out_valid_next = 1'b1;
            out_code_next  = verdict;
            all_ascii_next = 1'b1;
            pending_next   = 3'd0;
            err_next       = V_VALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_ascii_reg <= 1'b1;
            pending_reg   <= 3'd0;
            err_reg       <= V_VALID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cls_take)
            begin
                all_ascii_reg <= all_ascii_next;
                pending_reg   <= pending_next;
                err_reg       <= err_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_code_reg <= out_code_next;
    end

    assign empty        = !out_valid_reg;
    assign verdict_code = out_code_reg;
    assign is_utf8      = (out_code_reg == V_VALID);

    assign status.all_ascii   = all_ascii_reg;
    assign status.pending     = pending_reg;
    assign status.first_error = err_reg;

endmodule

FILE: hdl/utf8_stream_validator_core.sv
// Path: pushed words pass through the queue; the back end registers each last word's verdict.
// Throughput: one word per cycle, set by the back end's state update, unless a last
//   word waits for an unpopped verdict; a four-entry queue between classifier and
//   back end absorbs result-side stalls.
// Reset (rst_n low, asynchronous): queue emptied, no verdict waiting, string state cleared.
module utf8_stream_validator_core #(
    parameter int MAX_SEQ_LEN = 6
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       push,
    output logic       full,
    input  logic       pop,
    output logic       empty,
    output logic       is_utf8,
    output logic [2:0] verdict_code
);
    import usv_pkg::*;

    cls_t         front_cls;
    cls_t         head_cls;
    logic         q_empty;
    logic         take;
    back_status_t status;

    usv_front #(
        .MAX_SEQ_LEN(MAX_SEQ_LEN)
    ) u_front (
        .data_byte(data_byte),
        .last_byte(last_byte),
        .cls      (front_cls)
    );

    usv_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push && !full),
        .wr_data(front_cls),
        .rd_en  (take),
        .rd_data(head_cls),
        .q_full (full),
        .q_empty(q_empty)
    );

    usv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cls         (head_cls),
        .cls_avail   (!q_empty),
        .cls_take    (take),
        .pop         (pop),
        .empty       (empty),
        .is_utf8     (is_utf8),
        .verdict_code(verdict_code),
        .status      (status)
    );

    a_utf8_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (is_utf8 == (verdict_code == V_VALID)))
        else $error("is_utf8 disagrees with verdict");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (verdict_code <= V_TRUNC))
        else $error("verdict code out of range");

    a_ascii_clean: assert property (@(posedge clk) disable iff (!rst_n)
        status.all_ascii |-> (status.pending == 3'd0 && status.first_error == V_VALID))
        else $error("all-ascii string holds pending or error state");

    a_held_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(verdict_code)))
        else $error("waiting verdict lost or changed");

endmodule
